>>> design/cprr_pkg.sv
// Shared types and constants for the range-reduced polynomial cosine block.
package cprr_pkg;

  localparam int unsigned ANGLE_W  = 32;
  localparam int unsigned COEF_W   = 26;
  localparam int unsigned COS_W    = 18;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned ACC_W    = 34;
  localparam int unsigned SQ_W     = 32;
  localparam int unsigned CPRR_LATENCY = 15;

  // pi in Q2.32, pi / 2 in the same scale, floor(2^64 / pi_q32)
  localparam logic [33:0] PI_Q32     = 34'h3_243F_6A89;
  localparam logic [33:0] PI_HALF    = 34'h1_921F_B544;
  localparam logic [31:0] INV_PI_Q64 = 32'd1367130551;

  localparam logic signed [COEF_W-1:0] COEF_ZERO_RST   = 26'sd16777099;
  localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = -26'sd8387132;
  localparam logic signed [COEF_W-1:0] COEF_FOURTH_RST = 26'sd696036;
  localparam logic signed [COEF_W-1:0] COEF_SIXTH_RST  = -26'sd21324;

  localparam logic signed [COS_W-1:0] ONE_Q16     = 18'sd65536;
  localparam logic signed [COS_W-1:0] NEG_ONE_Q16 = -18'sd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_ZERO   = 4'd0,
    REG_COEF_SQUARE = 4'd1,
    REG_COEF_FOURTH = 4'd2,
    REG_COEF_SIXTH  = 4'd3
  } cprr_reg_e;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      is_last;
  } cprr_in_t;

  typedef struct packed {
    logic signed [COS_W-1:0] cos_value;
    logic                    last_out;
  } cprr_out_t;

  typedef struct packed {
    logic valid;
    logic odd;
    logic last;
  } cprr_tag_t;

endpackage

>>> design/cprr_horner_step.sv
// One Horner step: acc * r^2 registered, then rounded, scaled and added to a coefficient.
module cprr_horner_step (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cprr_pkg::cprr_tag_t                    tag_i,
  input  logic signed [cprr_pkg::ACC_W-1:0]      acc_i,
  input  logic        [cprr_pkg::SQ_W-1:0]       sq_i,
  input  logic signed [cprr_pkg::COEF_W-1:0]     coef_i,
  output cprr_pkg::cprr_tag_t                    tag_o,
  output logic signed [cprr_pkg::ACC_W-1:0]      acc_o,
  output logic        [cprr_pkg::SQ_W-1:0]       sq_o
);
  import cprr_pkg::*;

  localparam int unsigned PROD_W = ACC_W + SQ_W + 1;
  localparam logic signed [PROD_W-1:0] RND = PROD_W'(64'sd536870912);

  cprr_tag_t                 tag_a_q, tag_b_q;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic        [SQ_W-1:0]    sq_a_q, sq_b_q;
  logic signed [PROD_W-1:0]  rnd_sum;
  logic signed [ACC_W-1:0]   acc_d, acc_q;

  assign prod_d  = acc_i * $signed({1'b0, sq_i});
  assign rnd_sum = prod_q + RND;
  assign acc_d   = ACC_W'(coef_i) + $signed(rnd_sum[ACC_W+29:30]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sq_a_q <= sq_i;
    acc_q  <= acc_d;
    sq_b_q <= sq_a_q;
  end

  assign tag_o = tag_b_q;
  assign acc_o = acc_q;
  assign sq_o  = sq_b_q;

endmodule

>>> design/cosine_poly_range_reduced.sv
// Top level: pipelined cosine by range reduction about pi and an even Horner polynomial.
// Takes one angle (Q15.16 rad) per clock and returns cos in Q1.16, clamped to +/-1.0.
// Every cycle a start is taken (busy_o stays low); the result shows on out_o with
// done_o high for one cycle, in the order of the start transfers.
// The receiver cannot stall: each result must be taken in the cycle it is shown.
// The rate of one item per clock is set by the pipeline: a single multiplier per
// stage for the 1/pi estimate, k*pi, r^2 and the three Horner multiply-add steps.
// cfg_ready_o is always high; write coefficients only while no item is in flight.
module cosine_poly_range_reduced (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  cprr_pkg::cprr_in_t                  in_i,
  output logic                                done_o,
  output cprr_pkg::cprr_out_t                 out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cprr_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [cprr_pkg::COEF_W-1:0]         cfg_data_i
);
  import cprr_pkg::*;

  localparam logic signed [64:0] K_RND = 65'sd140737488355328;

  logic signed [COEF_W-1:0] coef_zero_q, coef_square_q, coef_fourth_q, coef_sixth_q;

  cprr_tag_t s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q, s5_tag_q, s6_tag_q, s7_tag_q, s8_tag_q;
  cprr_tag_t h1_tag, h2_tag, h3_tag;

  logic signed [ANGLE_W-1:0] s1_angle_q, s2_angle_q, s3_angle_q;
  logic signed [64:0]        s2_prod_d, s2_prod_q, s3_ksum;
  logic signed [15:0]        s3_kest;
  logic signed [50:0]        s3_kp_d, s3_kp_q;
  logic                      s3_k0_q, s4_k0_q;
  logic signed [47:0]        s4_x;
  logic signed [51:0]        s4_diff;
  logic signed [35:0]        s4_rp_q;
  logic                      s5_hi, s5_lo;
  logic signed [35:0]        s5_r_d;
  logic signed [33:0]        s5_r_q;
  logic signed [33:0]        s6_abs;
  logic        [31:0]        s6_m_q;
  logic        [63:0]        s7_mm_q, s8_sum;
  logic        [SQ_W-1:0]    s8_sq_q;

  logic signed [ACC_W-1:0]   h1_acc, h2_acc, h3_acc;
  logic        [SQ_W-1:0]    h1_sq, h2_sq, h3_sq;

  logic signed [ACC_W-1:0]   o_sum;
  logic signed [25:0]        o_y;
  logic signed [26:0]        o_yn;
  logic signed [COS_W-1:0]   o_clamp;
  cprr_out_t                 out_q;
  logic                      done_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_zero_q   <= COEF_ZERO_RST;
      coef_square_q <= COEF_SQUARE_RST;
      coef_fourth_q <= COEF_FOURTH_RST;
      coef_sixth_q  <= COEF_SIXTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COEF_ZERO:   coef_zero_q   <= $signed(cfg_data_i);
        REG_COEF_SQUARE: coef_square_q <= $signed(cfg_data_i);
        REG_COEF_FOURTH: coef_fourth_q <= $signed(cfg_data_i);
        REG_COEF_SIXTH:  coef_sixth_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // k estimate: round(angle * 2^64/pi_q32 / 2^48), off by at most one
  assign s2_prod_d = s1_angle_q * $signed({1'b0, INV_PI_Q64});
  assign s3_ksum   = s2_prod_q + K_RND;
  assign s3_kest   = $signed(s3_ksum[63:48]);
  assign s3_kp_d   = s3_kest * $signed({1'b0, PI_Q32});
  assign s4_x      = $signed({s3_angle_q, 16'h0000});
  assign s4_diff   = 52'(s4_x) - 52'(s3_kp_q);

  // one correction step brings r into [-pi/2, pi/2]
  assign s5_hi  = s4_rp_q > $signed({2'b00, PI_HALF});
  assign s5_lo  = s4_rp_q < -$signed({2'b00, PI_HALF});
  always_comb begin
    if (s5_hi) begin
      s5_r_d = s4_rp_q - $signed({2'b00, PI_Q32});
    end else if (s5_lo) begin
      s5_r_d = s4_rp_q + $signed({2'b00, PI_Q32});
    end else begin
      s5_r_d = s4_rp_q;
    end
  end

  assign s6_abs = s5_r_q[33] ? -s5_r_q : s5_r_q;
  assign s8_sum = s7_mm_q + 64'h0000_0000_8000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
      s4_tag_q <= '0;
      s5_tag_q <= '0;
      s6_tag_q <= '0;
      s7_tag_q <= '0;
      s8_tag_q <= '0;
    end else begin
      s1_tag_q <= '{valid: start_i && !busy_o, odd: 1'b0, last: in_i.is_last};
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
      s4_tag_q <= s3_tag_q;
      s5_tag_q <= '{valid: s4_tag_q.valid, odd: s4_k0_q ^ (s5_hi | s5_lo),
                    last: s4_tag_q.last};
      s6_tag_q <= s5_tag_q;
      s7_tag_q <= s6_tag_q;
      s8_tag_q <= s7_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_angle_q <= in_i.angle;
    s2_angle_q <= s1_angle_q;
    s2_prod_q  <= s2_prod_d;
    s3_angle_q <= s2_angle_q;
    s3_kp_q    <= s3_kp_d;
    s3_k0_q    <= s3_kest[0];
    s4_k0_q    <= s3_k0_q;
    s4_rp_q    <= s4_diff[35:0];
    s5_r_q     <= s5_r_d[33:0];
    s6_m_q     <= s6_abs[32:1];
    s7_mm_q    <= s6_m_q * s6_m_q;
    s8_sq_q    <= s8_sum[63:32];
  end

  cprr_horner_step u_horner_fourth (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (s8_tag_q),
    .acc_i  (ACC_W'(coef_sixth_q)),
    .sq_i   (s8_sq_q),
    .coef_i (coef_fourth_q),
    .tag_o  (h1_tag),
    .acc_o  (h1_acc),
    .sq_o   (h1_sq)
  );

  cprr_horner_step u_horner_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (h1_tag),
    .acc_i  (h1_acc),
    .sq_i   (h1_sq),
    .coef_i (coef_square_q),
    .tag_o  (h2_tag),
    .acc_o  (h2_acc),
    .sq_o   (h2_sq)
  );

  cprr_horner_step u_horner_zero (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (h2_tag),
    .acc_i  (h2_acc),
    .sq_i   (h2_sq),
    .coef_i (coef_zero_q),
    .tag_o  (h3_tag),
    .acc_o  (h3_acc),
    .sq_o   (h3_sq)
  );

  // h3_sq is the last tap of the r^2 delay line; it feeds nothing further
  assign o_sum = h3_acc + ACC_W'(35'sd128) + ACC_W'(h3_sq & '0);
  assign o_y   = $signed(o_sum[33:8]);
  assign o_yn  = h3_tag.odd ? -27'(o_y) : 27'(o_y);

  always_comb begin
    if (o_yn > 27'(ONE_Q16)) begin
      o_clamp = ONE_Q16;
    end else if (o_yn < 27'(NEG_ONE_Q16)) begin
      o_clamp = NEG_ONE_Q16;
    end else begin
      o_clamp = o_yn[COS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= h3_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= '{cos_value: o_clamp, last_out: h3_tag.last};
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

>>> design/cprr_checker.sv
// Port-level checks for the cosine block and the bind that attaches them.
module cprr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input cprr_pkg::cprr_in_t          in_i,
  input logic                        done_o,
  input cprr_pkg::cprr_out_t         out_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o
);
  import cprr_pkg::*;

  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##15 done_o)
    else $error("transfer in without result after fixed latency");

  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, CPRR_LATENCY))
    else $error("result without matching input transfer");

  a_last_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_o.last_out == $past(in_i.is_last, CPRR_LATENCY)))
    else $error("last flag not carried with its item");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((out_o.cos_value <= ONE_Q16) && (out_o.cos_value >= NEG_ONE_Q16)))
    else $error("cosine outside +/-1.0");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write held off");

endmodule

bind cosine_poly_range_reduced cprr_checker u_cprr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .in_i        (in_i),
  .done_o      (done_o),
  .out_o       (out_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

>>> sim/cos_result_checker.sv
`timescale 1ns / 1ps
// Checker for the range-reduced cosine block: predicts each result from the accepted angle.
module cos_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_o,
  input  cprr_pkg::cprr_in_t            in_i,
  input  logic                          done_o,
  input  cprr_pkg::cprr_out_t           out_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [cprr_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [cprr_pkg::COEF_W-1:0]   cfg_data_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   pending_o
);
  import cprr_pkg::*;

  localparam longint PI_Q2_32 = 64'sh3_243F_6A89;
  localparam longint COS_ONE  = 64'sd65536;

  logic signed [COEF_W-1:0] coef_zero_q;
  logic signed [COEF_W-1:0] coef_square_q;
  logic signed [COEF_W-1:0] coef_fourth_q;
  logic signed [COEF_W-1:0] coef_sixth_q;

  cprr_out_t   cos_expected_q [$];
  int unsigned mismatches = 0;

  assign fail_cnt_o = mismatches;

  // acc * r^2 in Q.30, rounded half up, plus the next coefficient
  function automatic longint horner_mac(longint acc, logic [63:0] r_sq,
                                        logic signed [COEF_W-1:0] coef);
    longint prod;
    prod = acc * longint'(r_sq);
    return longint'(coef) + ((prod + 64'sd536870912) >>> 30);
  endfunction

  function automatic cprr_out_t predict_cos(cprr_in_t item);
    longint     x_q32;
    longint     quot;
    longint     rem;
    longint     r_q32;
    longint     acc;
    logic [63:0] r_half;
    logic [63:0] r_sq;
    cprr_out_t  res;
    x_q32 = longint'($signed(item.angle)) * 64'sd65536;
    quot  = x_q32 / PI_Q2_32;
    rem   = x_q32 % PI_Q2_32;
    if (rem < 0) begin
      rem  = rem + PI_Q2_32;
      quot = quot - 1;
    end
    if (2 * rem > PI_Q2_32) begin
      quot  = quot + 1;
      r_q32 = rem - PI_Q2_32;
    end else begin
      r_q32 = rem;
    end
    r_half = (r_q32 < 0) ? -r_q32 : r_q32;
    r_half = r_half >> 1;
    r_sq   = (r_half * r_half + 64'h8000_0000) >> 32;
    acc = longint'(coef_sixth_q);
    acc = horner_mac(acc, r_sq, coef_fourth_q);
    acc = horner_mac(acc, r_sq, coef_square_q);
    acc = horner_mac(acc, r_sq, coef_zero_q);
    acc = (acc + 64'sd128) >>> 8;
    if (quot[0]) begin
      acc = -acc;
    end
    if (acc > COS_ONE) begin
      acc = COS_ONE;
    end
    if (acc < -COS_ONE) begin
      acc = -COS_ONE;
    end
    res.cos_value = acc[COS_W-1:0];
    res.last_out  = item.is_last;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    cprr_out_t want;
    if (!rst_ni) begin
      coef_zero_q   <= COEF_ZERO_RST;
      coef_square_q <= COEF_SQUARE_RST;
      coef_fourth_q <= COEF_FOURTH_RST;
      coef_sixth_q  <= COEF_SIXTH_RST;
      cos_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_COEF_ZERO:   coef_zero_q   <= cfg_data_i;
          REG_COEF_SQUARE: coef_square_q <= cfg_data_i;
          REG_COEF_FOURTH: coef_fourth_q <= cfg_data_i;
          REG_COEF_SIXTH:  coef_sixth_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        cos_expected_q.push_back(predict_cos(in_i));
      end
      if (done_o) begin
        if (cos_expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got cos_value %0d last_out %0b",
                   $time, $signed(out_o.cos_value), out_o.last_out);
          mismatches++;
        end else begin
          want = cos_expected_q.pop_front();
          if (out_o.cos_value !== want.cos_value) begin
            $display("%0t: cos_value mismatch, expected %0d, got %0d", $time,
                     $signed(want.cos_value), $signed(out_o.cos_value));
            mismatches++;
          end
          if (out_o.last_out !== want.last_out) begin
            $display("%0t: last_out mismatch, expected %0b, got %0b", $time,
                     want.last_out, out_o.last_out);
            mismatches++;
          end
        end
      end
      pending_o <= cos_expected_q.size();
    end
  end

endmodule

>>> sim/tb_cosine_poly_range_reduced.sv
`timescale 1ns / 1ps
// Testbench top for the range-reduced cosine block: angle and coefficient stimulus, verdict.
module tb_cosine_poly_range_reduced;
  import cprr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = CPRR_LATENCY + 5;
  localparam real         PI_REAL       = 3.14159265358979;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  // 1, -1/2, 1/24, -1/720 in Q1.24
  localparam logic signed [COEF_W-1:0] TAYLOR_ZERO   = 26'sd16777216;
  localparam logic signed [COEF_W-1:0] TAYLOR_SQUARE = -26'sd8388608;
  localparam logic signed [COEF_W-1:0] TAYLOR_FOURTH = 26'sd699051;
  localparam logic signed [COEF_W-1:0] TAYLOR_SIXTH  = -26'sd23302;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  cprr_in_t            in_i;
  logic                done_o;
  cprr_out_t           out_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [IDX_W-1:0]    cfg_index_i;
  logic [COEF_W-1:0]   cfg_data_i;
  int unsigned         fail_cnt;
  int unsigned         pending_cnt;

  // zero, +-1 lsb, extremes, multiples of pi/2, one radian, bit patterns, far multiples of pi
  logic [ANGLE_W-1:0] corner_angles [20] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'd102944, -32'sd102944, 32'd205887, -32'sd205887, 32'd308831,
    32'd411775, 32'd617662, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd2058874162, -32'sd2058874162, 32'h7FFF_0000
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cosine_poly_range_reduced i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .done_o      (done_o),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  cos_result_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .done_o      (done_o),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt)
  );

  initial begin
    #2_000_000;
    $display("cosine_poly_range_reduced test failed");
    $finish;
  end

  task automatic send_angle(input logic [ANGLE_W-1:0] angle, input logic last);
    cprr_in_t item;
    item.angle   = angle;
    item.is_last = last;
    start_i <= 1'b1;
    in_i    <= item;
    do @(posedge clk_i); while (busy_o);
  endtask

  // n must be at least one
  task automatic idle_sender(input int unsigned n);
    start_i <= 1'b0;
    in_i    <= {$urandom(), 1'($urandom())};
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_index_i <= IDX_W'($urandom());
    cfg_data_i  <= COEF_W'($urandom());
    @(posedge clk_i);
  endtask

  // waits for the pipeline to empty before writing
  task automatic load_coefs(input logic [COEF_W-1:0] c_zero, input logic [COEF_W-1:0] c_square,
                            input logic [COEF_W-1:0] c_fourth, input logic [COEF_W-1:0] c_sixth);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_coef(REG_COEF_ZERO, c_zero);
    write_coef(REG_COEF_SQUARE, c_square);
    write_coef(REG_COEF_FOURTH, c_fourth);
    write_coef(REG_COEF_SIXTH, c_sixth);
    // unmapped index, must be ignored
    write_coef(IDX_W'($urandom_range(2 ** IDX_W - 1, REG_COEF_SIXTH + 1)), COEF_W'($urandom()));
  endtask

  function automatic logic [ANGLE_W-1:0] random_angle();
    int unsigned pick;
    int unsigned mult;
    real         target;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      return $urandom();
    end
    if (pick < 6) begin
      return $urandom_range(0, 2 ** 20) - 2 ** 19;
    end
    if (pick < 9) begin
      // near a multiple of pi/2, where the reduction flips
      mult   = $urandom_range(0, 10000);
      target = (real'(mult) + 0.5 * real'($urandom_range(0, 1))) * PI_REAL * 65536.0;
      if ($urandom_range(0, 1) != 0) begin
        target = -target;
      end
      return $rtoi(target) + $urandom_range(0, 8) - 4;
    end
    return corner_angles[$urandom_range(0, 19)];
  endfunction

  task automatic run_random(input int unsigned count, input bit hold_mid);
    int unsigned sent;
    int unsigned burst;
    bit          held;
    sent = 0;
    held = 1'b0;
    while (sent < count) begin
      burst = $urandom_range(1, 48);
      while (burst != 0 && sent < count) begin
        send_angle(random_angle(), 1'($urandom()));
        sent++;
        burst--;
      end
      if (hold_mid && !held && sent >= count / 2) begin
        wait_results();
        held = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 20));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_angles[i]) begin
      send_angle(corner_angles[i], i[0]);
    end
    run_random(400, 1'b1);

    load_coefs(TAYLOR_ZERO, TAYLOR_SQUARE, TAYLOR_FOURTH, TAYLOR_SIXTH);
    run_random(220, 1'b0);

    // degree four
    load_coefs(COEF_ZERO_RST, COEF_SQUARE_RST, COEF_FOURTH_RST, '0);
    run_random(220, 1'b0);

    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    run_random(180, 1'b0);

    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    run_random(180, 1'b0);

    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    run_random(150, 1'b0);

    repeat (3) begin
      load_coefs(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                 COEF_W'($urandom()));
      run_random(100, 1'b0);
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("cosine_poly_range_reduced test passed");
    end else begin
      $display("cosine_poly_range_reduced test failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/cprr_pkg.sv
design/cprr_horner_step.sv
design/cosine_poly_range_reduced.sv
design/cprr_checker.sv
sim/cos_result_checker.sv
sim/tb_cosine_poly_range_reduced.sv
